// ----- src/volume_convolution_3d_defines.svh -----
// Assertion macros for the 3D convolution block.
// No dependencies; taken in by the top level with `include.
`ifndef VOLUME_CONVOLUTION_3D_DEFINES_SVH
`define VOLUME_CONVOLUTION_3D_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every rising clock edge outside reset
`define VC3D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vc3d assertion failed");
// condition never true outside reset
`define VC3D_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("vc3d forbidden condition seen");
`else
`define VC3D_ASSERT(lbl, prop)
`define VC3D_NEVER(lbl, cond)
`endif

`endif

// ----- src/vc3d_pkg.sv -----
// Package for the 3D convolution block: field widths, defaults and codes.
// No dependencies; used by volume_convolution_3d.
package vc3d_pkg;

  localparam int MaxDim     = 32;
  localparam int MaxRadius  = 3;
  localparam int SampleBits = 16;

  localparam int PosW     = 5;
  localparam int OpW      = 2;
  localparam int DimCfgW  = 6;
  localparam int RadCfgW  = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 6;
  localparam int SumW     = 48;
  // signed working width for neighbour coordinates, covers dims up to 256
  localparam int CoordW   = 10;

  localparam logic [DimCfgW-1:0] DimReset = 6'd32;
  localparam logic [RadCfgW-1:0] RadReset = 2'd1;

  typedef enum logic [OpW-1:0] {
    OpLoadCoeff = 2'd0,
    OpLoadVoxel = 2'd1,
    OpQuery     = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgVolWidth  = 3'd0,
    CfgVolHeight = 3'd1,
    CfgVolDepth  = 3'd2,
    CfgRadiusX   = 3'd3,
    CfgRadiusY   = 3'd4,
    CfgRadiusZ   = 3'd5,
    CfgZeroPad   = 3'd6
  } cfg_idx_e;

endpackage

// ----- src/volume_convolution_3d.sv -----
// 3D convolution over a stored volume with zero or clamp-to-edge padding.
// A query walks the kernel box one tap per cycle through a single voxel
// memory read port and one multiply-accumulate unit. Its result passes two
// pipeline stages behind the last tap and then the result register. A query
// outside the volume skips the scan and goes from the drain state to the
// result register. No new request is taken while a query is in progress or
// while its result waits to enter the output register. Loads are taken while
// a result waits at the output. Memories need no clearing after reset.
// Depends on vc3d_pkg and volume_convolution_3d_defines.svh.
`include "volume_convolution_3d_defines.svh"

module volume_convolution_3d #(
  parameter int MAX_DIM     = vc3d_pkg::MaxDim,
  parameter int MAX_RADIUS  = vc3d_pkg::MaxRadius,
  parameter int SAMPLE_BITS = vc3d_pkg::SampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          cfg_we_i,
  input  logic [vc3d_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vc3d_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vc3d_pkg::OpW-1:0]      op_i,
  input  logic [vc3d_pkg::PosW-1:0]     pos_x_i,
  input  logic [vc3d_pkg::PosW-1:0]     pos_y_i,
  input  logic [vc3d_pkg::PosW-1:0]     pos_z_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [vc3d_pkg::SumW-1:0] conv_sum_o,
  output logic                          status_o
);

  localparam int DimW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int VoxAw  = 3 * DimW;
  localparam int KSide  = 2 * MAX_RADIUS + 1;
  localparam int KW     = $clog2(KSide);
  localparam int CoefAw = 3 * KW;
  localparam int CW     = vc3d_pkg::CoordW;
  localparam int ProdW  = 2 * SAMPLE_BITS;
  localparam int SumW   = vc3d_pkg::SumW;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StDrain = 3'b100
  } state_e;

  // configuration registers
  logic [vc3d_pkg::DimCfgW-1:0] width_q, height_q, depth_q;
  logic [vc3d_pkg::RadCfgW-1:0] rad_x_q, rad_y_q, rad_z_q;
  logic                         zero_pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= vc3d_pkg::DimReset;
      height_q   <= vc3d_pkg::DimReset;
      depth_q    <= vc3d_pkg::DimReset;
      rad_x_q    <= vc3d_pkg::RadReset;
      rad_y_q    <= vc3d_pkg::RadReset;
      rad_z_q    <= vc3d_pkg::RadReset;
      zero_pad_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (vc3d_pkg::cfg_idx_e'(cfg_idx_i))
        vc3d_pkg::CfgVolWidth:  width_q    <= cfg_data_i;
        vc3d_pkg::CfgVolHeight: height_q   <= cfg_data_i;
        vc3d_pkg::CfgVolDepth:  depth_q    <= cfg_data_i;
        vc3d_pkg::CfgRadiusX:   rad_x_q    <= cfg_data_i[vc3d_pkg::RadCfgW-1:0];
        vc3d_pkg::CfgRadiusY:   rad_y_q    <= cfg_data_i[vc3d_pkg::RadCfgW-1:0];
        vc3d_pkg::CfgRadiusZ:   rad_z_q    <= cfg_data_i[vc3d_pkg::RadCfgW-1:0];
        vc3d_pkg::CfgZeroPad:   zero_pad_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective sizes after limiting to the build maxima
  logic [CW-1:0] w_eff, h_eff, d_eff;
  logic [KW-1:0] rx_eff, ry_eff, rz_eff;

  assign w_eff  = (CW'(width_q)  > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(width_q);
  assign h_eff  = (CW'(height_q) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(height_q);
  assign d_eff  = (CW'(depth_q)  > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(depth_q);
  assign rx_eff = (CW'(rad_x_q) > CW'(MAX_RADIUS)) ? KW'(MAX_RADIUS) : KW'(rad_x_q);
  assign ry_eff = (CW'(rad_y_q) > CW'(MAX_RADIUS)) ? KW'(MAX_RADIUS) : KW'(rad_y_q);
  assign rz_eff = (CW'(rad_z_q) > CW'(MAX_RADIUS)) ? KW'(MAX_RADIUS) : KW'(rad_z_q);

  function automatic logic outside(input logic [CW-1:0] c, input logic [CW-1:0] n);
    outside = c[CW-1] || (c >= n);
  endfunction

  function automatic logic [DimW-1:0] clamp_coord(input logic [CW-1:0] c,
                                                  input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = c;
    if (c[CW-1])
      r = '0;
    else if (c >= n)
      r = n - CW'(1);
    clamp_coord = r[DimW-1:0];
  endfunction

  // request decode
  state_e state_q, state_d;
  logic   in_acc, pos_in_vol, coef_in_box;
  logic   vox_we, coef_we, query_go;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_in_vol  = (CW'(pos_x_i) < w_eff) && (CW'(pos_y_i) < h_eff)
                    && (CW'(pos_z_i) < d_eff);
  assign coef_in_box = (CW'(pos_x_i) < CW'({rx_eff, 1'b1}))
                    && (CW'(pos_y_i) < CW'({ry_eff, 1'b1}))
                    && (CW'(pos_z_i) < CW'({rz_eff, 1'b1}));

  always_comb begin
    vox_we   = 1'b0;
    coef_we  = 1'b0;
    query_go = 1'b0;
    if (in_acc) begin
      unique case (vc3d_pkg::op_e'(op_i))
        vc3d_pkg::OpLoadCoeff: coef_we  = coef_in_box;
        vc3d_pkg::OpLoadVoxel: vox_we   = pos_in_vol;
        vc3d_pkg::OpQuery:     query_go = 1'b1;
        default: ;
      endcase
    end
  end

  // kernel tap sequencer
  logic [vc3d_pkg::PosW-1:0] qx_q, qy_q, qz_q;
  logic [KW-1:0] kx_q, ky_q, kz_q, kx_d, ky_d, kz_d;
  logic          last_x, last_y, last_z;

  assign last_x = (kx_q == KW'({rx_eff, 1'b0}));
  assign last_y = (ky_q == KW'({ry_eff, 1'b0}));
  assign last_z = (kz_q == KW'({rz_eff, 1'b0}));

  logic s1_vld_q, s2_vld_q, pipe_busy, emit;

  assign pipe_busy = s1_vld_q || s2_vld_q;
  assign emit      = (state_q == StDrain) && !pipe_busy && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d = state_q;
    kx_d    = kx_q;
    ky_d    = ky_q;
    kz_d    = kz_q;
    unique case (state_q)
      StIdle: begin
        kx_d = '0;
        ky_d = '0;
        kz_d = '0;
        if (query_go) state_d = pos_in_vol ? StScan : StDrain;
      end
      StScan: begin
        kx_d = last_x ? '0 : kx_q + KW'(1);
        if (last_x) begin
          ky_d = last_y ? '0 : ky_q + KW'(1);
          if (last_y) begin
            kz_d = kz_q + KW'(1);
            if (last_z) state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (emit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      kx_q    <= '0;
      ky_q    <= '0;
      kz_q    <= '0;
    end else begin
      state_q <= state_d;
      kx_q    <= kx_d;
      ky_q    <= ky_d;
      kz_q    <= kz_d;
    end
  end

  // neighbour coordinates for the current tap
  logic [CW-1:0] ix, iy, iz;
  logic          tap_out, tap_vld;
  logic [VoxAw-1:0]  vox_rd_addr, vox_wr_addr;
  logic [CoefAw-1:0] coef_rd_addr, coef_wr_addr;

  assign ix = CW'(qx_q) + CW'(kx_q) - CW'(rx_eff);
  assign iy = CW'(qy_q) + CW'(ky_q) - CW'(ry_eff);
  assign iz = CW'(qz_q) + CW'(kz_q) - CW'(rz_eff);

  assign tap_out = outside(ix, w_eff) || outside(iy, h_eff) || outside(iz, d_eff);
  assign tap_vld = (state_q == StScan) && !(zero_pad_q && tap_out);

  assign vox_rd_addr  = {clamp_coord(iz, d_eff), clamp_coord(iy, h_eff),
                         clamp_coord(ix, w_eff)};
  assign vox_wr_addr  = {DimW'(pos_z_i), DimW'(pos_y_i), DimW'(pos_x_i)};
  assign coef_rd_addr = {kz_q, ky_q, kx_q};
  assign coef_wr_addr = {KW'(pos_z_i), KW'(pos_y_i), KW'(pos_x_i)};

  // stores
  logic [SAMPLE_BITS-1:0] vox_mem  [2**VoxAw];
  logic [SAMPLE_BITS-1:0] coef_mem [2**CoefAw];
  logic signed [SAMPLE_BITS-1:0] vox_rd_q, coef_rd_q;

  always_ff @(posedge clk_i) begin
    if (vox_we) vox_mem[vox_wr_addr] <= sample_i;
    vox_rd_q <= vox_mem[vox_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[coef_wr_addr] <= sample_i;
    coef_rd_q <= coef_mem[coef_rd_addr];
  end

  // multiply-accumulate
  logic signed [ProdW-1:0] prod_q;
  logic signed [SumW-1:0]  acc_q, sum_q;
  logic                    err_q, status_q, out_valid_q;

  always_ff @(posedge clk_i) begin
    prod_q <= vox_rd_q * coef_rd_q;
    if (query_go) begin
      qx_q <= pos_x_i;
      qy_q <= pos_y_i;
      qz_q <= pos_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= tap_vld;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      acc_q <= '0;
      err_q <= !pos_in_vol;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + SumW'(prod_q);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sum_q    <= acc_q;
      status_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign conv_sum_o  = sum_q;
  assign status_o    = status_q;

  `VC3D_ASSERT(a_idle_pipe_empty, (state_q == StIdle) |-> !pipe_busy)
  `VC3D_ASSERT(a_result_from_drain, $rose(out_valid_o) |-> $past(state_q == StDrain))
  `VC3D_NEVER(a_tap_in_box, (state_q == StScan) && (kx_q > KW'({rx_eff, 1'b0})))
  `VC3D_ASSERT(a_query_busy, query_go |=> in_stall_o)

endmodule

// ----- verif/vc3d_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for volume_convolution_3d: mirrors the config registers and both stores,
// predicts every query result and compares it with the output request.
// Depends on vc3d_pkg.
module vc3d_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vc3d_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [vc3d_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [vc3d_pkg::OpW-1:0]            op_i,
  input  logic [vc3d_pkg::PosW-1:0]           pos_x_i,
  input  logic [vc3d_pkg::PosW-1:0]           pos_y_i,
  input  logic [vc3d_pkg::PosW-1:0]           pos_z_i,
  input  logic signed [vc3d_pkg::SampleBits-1:0] sample_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [vc3d_pkg::SumW-1:0]    conv_sum_i,
  input  logic                                status_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import vc3d_pkg::*;

  localparam int KernelSide = 2 * MaxRadius + 1;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic                   status;
  } conv_result_t;

  logic signed [SampleBits-1:0] voxel_mem [MaxDim*MaxDim*MaxDim];
  logic signed [SampleBits-1:0] coeff_mem [KernelSide*KernelSide*KernelSide];

  logic [DimCfgW-1:0] vol_w = DimReset;
  logic [DimCfgW-1:0] vol_h = DimReset;
  logic [DimCfgW-1:0] vol_d = DimReset;
  logic [RadCfgW-1:0] rad_x = RadReset;
  logic [RadCfgW-1:0] rad_y = RadReset;
  logic [RadCfgW-1:0] rad_z = RadReset;
  logic               zero_pad = 1'b1;

  conv_result_t awaited_results [$];

  function automatic int eff_dim(logic [DimCfgW-1:0] raw);
    return (raw > MaxDim) ? MaxDim : int'(raw);
  endfunction

  function automatic int clamp_to(int v, int n);
    if (v > n - 1) v = n - 1;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic conv_result_t convolve_at(int px, int py, int pz);
    conv_result_t res;
    int w, h, d, rx, ry, rz, ix, iy, iz;
    longint acc;
    w = eff_dim(vol_w);
    h = eff_dim(vol_h);
    d = eff_dim(vol_d);
    rx = int'(rad_x);
    ry = int'(rad_y);
    rz = int'(rad_z);
    acc = 0;
    res.sum = '0;
    res.status = 1'b0;
    if (!(px < w && py < h && pz < d)) begin
      res.status = 1'b1;
      return res;
    end
    for (int kz = 0; kz < 2 * rz + 1; kz++) begin
      for (int ky = 0; ky < 2 * ry + 1; ky++) begin
        for (int kx = 0; kx < 2 * rx + 1; kx++) begin
          ix = px + kx - rx;
          iy = py + ky - ry;
          iz = pz + kz - rz;
          if (!zero_pad) begin
            ix = clamp_to(ix, w);
            iy = clamp_to(iy, h);
            iz = clamp_to(iz, d);
          end
          if (ix >= 0 && ix < w && iy >= 0 && iy < h && iz >= 0 && iz < d) begin
            acc += longint'(voxel_mem[(iz * MaxDim + iy) * MaxDim + ix])
                 * longint'(coeff_mem[(kz * KernelSide + ky) * KernelSide + kx]);
          end
        end
      end
    end
    res.sum = acc[SumW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int px, py, pz;
    conv_result_t head;
    px = int'(pos_x_i);
    py = int'(pos_y_i);
    pz = int'(pos_z_i);
    if (!rst_ni) begin
      vol_w = DimReset;
      vol_h = DimReset;
      vol_d = DimReset;
      rad_x = RadReset;
      rad_y = RadReset;
      rad_z = RadReset;
      zero_pad = 1'b1;
      awaited_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result request: conv_sum %0d status %0b", conv_sum_i, status_i);
          fail_count_o++;
        end else begin
          head = awaited_results.pop_front();
          if (conv_sum_i !== head.sum) begin
            $error("conv_sum: expected %0d, got %0d", head.sum, conv_sum_i);
            fail_count_o++;
          end
          if (status_i !== head.status) begin
            $error("status: expected %0b, got %0b", head.status, status_i);
            fail_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgVolWidth:  vol_w = cfg_data_i;
          CfgVolHeight: vol_h = cfg_data_i;
          CfgVolDepth:  vol_d = cfg_data_i;
          CfgRadiusX:   rad_x = cfg_data_i[RadCfgW-1:0];
          CfgRadiusY:   rad_y = cfg_data_i[RadCfgW-1:0];
          CfgRadiusZ:   rad_z = cfg_data_i[RadCfgW-1:0];
          CfgZeroPad:   zero_pad = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        case (op_i)
          OpLoadCoeff: begin
            if (px < 2 * int'(rad_x) + 1 && py < 2 * int'(rad_y) + 1
                && pz < 2 * int'(rad_z) + 1)
              coeff_mem[(pz * KernelSide + py) * KernelSide + px] = sample_i;
          end
          OpLoadVoxel: begin
            if (px < eff_dim(vol_w) && py < eff_dim(vol_h) && pz < eff_dim(vol_d))
              voxel_mem[(pz * MaxDim + py) * MaxDim + px] = sample_i;
          end
          OpQuery: awaited_results.push_back(convolve_at(px, py, pz));
          default: ;
        endcase
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for volume_convolution_3d: reset, register set-up per phase,
// directed and random requests with random idling; verdict from vc3d_checker.
module tb_top;
  import vc3d_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int KernelSide     = 2 * MaxRadius + 1;
  localparam int CycleLimit     = 3_000_000;
  localparam int SettleCycles   = 12;
  localparam int EndCycles      = 400;
  localparam int NumPhases      = 9;
  localparam int RandomPerPhase = 128;
  localparam logic [SampleBits-1:0] EdgeSamples [8] = '{
    16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h4000, 16'hC000, 16'h5555
  };

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [CfgIdxW-1:0]           cfg_idx = '0;
  logic [CfgDataW-1:0]          cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [OpW-1:0]               op = '0;
  logic [PosW-1:0]              pos_x = '0;
  logic [PosW-1:0]              pos_y = '0;
  logic [PosW-1:0]              pos_z = '0;
  logic signed [SampleBits-1:0] sample = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SumW-1:0]       conv_sum;
  logic                         status;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  // stimulus view of the volume and kernel, used to avoid reading unwritten entries
  int cur_w = 32, cur_h = 32, cur_d = 32;
  int cur_rx = 1, cur_ry = 1, cur_rz = 1;
  bit voxel_known [MaxDim*MaxDim*MaxDim];
  bit coeff_known [KernelSide*KernelSide*KernelSide];

  volume_convolution_3d i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .pos_z_i     (pos_z),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .conv_sum_o  (conv_sum),
    .status_o    (status)
  );

  vc3d_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .conv_sum_i   (conv_sum),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int voxel_addr(int x, int y, int z);
    return (z * MaxDim + y) * MaxDim + x;
  endfunction

  function automatic int coeff_addr(int kx, int ky, int kz);
    return (kz * KernelSide + ky) * KernelSide + kx;
  endfunction

  task automatic push_request(input logic [OpW-1:0] code, input int x, input int y,
                              input int z, input logic [SampleBits-1:0] smp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    if (code == OpLoadVoxel && x < cur_w && y < cur_h && z < cur_d)
      voxel_known[voxel_addr(x, y, z)] = 1'b1;
    if (code == OpLoadCoeff && x <= 2 * cur_rx && y <= 2 * cur_ry && z <= 2 * cur_rz)
      coeff_known[coeff_addr(x, y, z)] = 1'b1;
    op = code;
    pos_x = PosW'(x);
    pos_y = PosW'(y);
    pos_z = PosW'(z);
    sample = smp;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_and_settle(input int extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = CfgDataW'(value);
  endtask

  task automatic configure(input int w, input int h, input int d, input int rx,
                           input int ry, input int rz, input int pad);
    write_reg(CfgVolWidth, w);
    write_reg(CfgVolHeight, h);
    write_reg(CfgVolDepth, d);
    write_reg(CfgRadiusX, rx);
    write_reg(CfgRadiusY, ry);
    write_reg(CfgRadiusZ, rz);
    write_reg(CfgZeroPad, pad);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_w = (w > MaxDim) ? MaxDim : w;
    cur_h = (h > MaxDim) ? MaxDim : h;
    cur_d = (d > MaxDim) ? MaxDim : d;
    cur_rx = rx;
    cur_ry = ry;
    cur_rz = rz;
  endtask

  // write every voxel of the volume and every tap of the kernel box not yet known
  task automatic fill_unknown;
    for (int z = 0; z < cur_d; z++)
      for (int y = 0; y < cur_h; y++)
        for (int x = 0; x < cur_w; x++)
          if (!voxel_known[voxel_addr(x, y, z)])
            push_request(OpLoadVoxel, x, y, z, SampleBits'($urandom));
    for (int kz = 0; kz <= 2 * cur_rz; kz++)
      for (int ky = 0; ky <= 2 * cur_ry; ky++)
        for (int kx = 0; kx <= 2 * cur_rx; kx++)
          if (!coeff_known[coeff_addr(kx, ky, kz)])
            push_request(OpLoadCoeff, kx, ky, kz, SampleBits'($urandom));
  endtask

  task automatic random_request;
    int pick, x, y, z;
    logic [OpW-1:0] code;
    bit vol_full;
    pick = $urandom_range(99);
    x = $urandom_range(31);
    y = $urandom_range(31);
    z = $urandom_range(31);
    vol_full = (cur_w > 0 && cur_h > 0 && cur_d > 0);
    if (pick < 45) code = OpQuery;
    else if (pick < 75) code = OpLoadVoxel;
    else if (pick < 95) code = OpLoadCoeff;
    else code = OpUnused;
    if (vol_full && (pick < 35 || (pick >= 45 && pick < 70))) begin
      x = $urandom_range(cur_w - 1);
      y = $urandom_range(cur_h - 1);
      z = $urandom_range(cur_d - 1);
    end else if (pick >= 75 && pick < 90) begin
      x = $urandom_range(2 * cur_rx);
      y = $urandom_range(2 * cur_ry);
      z = $urandom_range(2 * cur_rz);
    end
    push_request(code, x, y, z, SampleBits'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero-padded corner query needs only the upper taps
    send_idle_pct = 22;
    recv_stall_pct = 59;
    for (int i = 0; i < 8; i++)
      push_request(OpLoadCoeff, 1 + i[0], 1 + i[1], 1 + i[2], EdgeSamples[i]);
    for (int i = 0; i < 8; i++)
      push_request(OpLoadVoxel, i[0], i[1], i[2], EdgeSamples[7 - i]);
    push_request(OpLoadCoeff, 31, 31, 31, 16'h7FFF);
    push_request(OpUnused, 31, 31, 31, 16'hFFFF);
    push_request(OpLoadVoxel, 31, 31, 31, 16'h8000);
    push_request(OpQuery, 0, 0, 0, 16'hFFFF);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 22;
        recv_stall_pct = 59;
      end else if (ph < 6) begin
        send_idle_pct = 59;
        recv_stall_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      drain_and_settle(SettleCycles);
      case (ph)
        0: configure(63, 1, 1, 3, 0, 0, 0);
        1: configure(1, 32, 1, 0, 3, 0, 1);
        2: configure(1, 1, 32, 0, 0, 3, 0);
        3: configure(0, 5, 5, 1, 1, 1, 1);
        4: configure(4, 3, 5, 3, 3, 3, 0);
        6: configure(3, 3, 3, 2, 1, 0, 1);
        8: configure(2, 7, 3, 3, 3, 3, 1);
        default: configure($urandom_range(6, 1), $urandom_range(6, 1), $urandom_range(6, 1),
                           $urandom_range(3), $urandom_range(3), $urandom_range(3),
                           $urandom_range(1));
      endcase
      fill_unknown();
      repeat (RandomPerPhase) random_request();
    end

    drain_and_settle(EndCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
